/* hdl/tscp_pkg.sv */
// Shared types, constants and constant helpers for the sine/cosine/tangent evaluator.
`default_nettype none
package tscp_pkg;

	// pi with 60 fraction bits
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef enum logic [1:0] {
		CMD_SIN = 2'd0,
		CMD_COS = 2'd1,
		CMD_TAN = 2'd2
	} cmd_t;

	typedef struct packed {
		logic vld;
		logic [1:0] cmd;
	} ctl_t;

	function automatic logic [63:0] pi_q(input int fb);
		return (PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
	endfunction

	function automatic logic [63:0] two_pi_q(input int fb);
		return (PI_Q60 + (64'd1 << (58 - fb))) >> (59 - fb);
	endfunction

	function automatic logic [63:0] half_pi_q(input int fb);
		return (PI_Q60 + (64'd1 << (60 - fb))) >> (61 - fb);
	endfunction

endpackage
`default_nettype wire

/* hdl/tscp_reduce.sv */
// Angle reduction to [-pi, pi): one compare-subtract of a scaled 2*pi per stage.
`default_nettype none
module tscp_reduce import tscp_pkg::*; #(
	parameter int AW = 32,
	parameter int FB = 24
) (
	input  wire logic                clk,
	input  wire logic signed [AW:0]  ang,
	output logic signed [FB+3:0]     xn_s
);
	localparam int TW    = AW + 3;
	localparam int NSTEP = AW - FB;
	localparam logic [63:0] PI_Q     = pi_q(FB);
	localparam logic [63:0] TWO_PI_Q = two_pi_q(FB);
	localparam logic [TW-1:0] OFS    = TW'(TWO_PI_Q << (AW - FB - 1));

	logic [TW-1:0] r_s [0:NSTEP];
	logic signed [TW:0] t_sum;

	// bias by a multiple of 2*pi so the remainder search stays unsigned
	assign t_sum = (TW+1)'(ang) + $signed({1'b0, PI_Q[TW-1:0]}) + $signed({1'b0, OFS});

	always_ff @(posedge clk) begin
		r_s[0] <= t_sum[TW-1:0];
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		localparam logic [TW-1:0] DV = TW'(TWO_PI_Q << (NSTEP - 1 - i));
		always_ff @(posedge clk) begin
			r_s[i+1] <= (r_s[i] >= DV) ? r_s[i] - DV : r_s[i];
		end
	end

	always_ff @(posedge clk) begin
		xn_s <= $signed({1'b0, r_s[NSTEP][FB+2:0]}) - $signed({1'b0, PI_Q[FB+2:0]});
	end

endmodule
`default_nettype wire

/* hdl/tscp_poly.sv */
// Seventh-order sine polynomial in Horner form, one rounded product per stage.
`default_nettype none
module tscp_poly import tscp_pkg::*; #(
	parameter int FB = 24
) (
	input  wire logic                clk,
	input  wire logic signed [FB+3:0] xn,
	output logic signed [FB+2:0]     s_s5
);
	localparam int X2W = FB + 5;
	localparam longint ONE_Q = 64'sd1 <<< FB;
	localparam logic signed [X2W-1:0] K1_Q = X2W'(ONE_Q);
	localparam logic signed [X2W-1:0] K3_Q = X2W'((ONE_Q + 3) / 6);
	localparam logic signed [X2W-1:0] K5_Q = X2W'((ONE_Q + 60) / 120);
	localparam logic signed [X2W-1:0] K7_Q = X2W'((ONE_Q + 2520) / 5040);
	localparam logic [2*X2W-1:0] HALF = (2*X2W)'(1) << (FB - 1);

	// round(a*b / 2^FB), ties away from zero
	function automatic logic signed [X2W-1:0] fmul(input logic signed [X2W-1:0] a,
			input logic signed [X2W-1:0] b);
		logic [X2W-1:0] ma;
		logic [X2W-1:0] mb;
		logic [2*X2W-1:0] pr;
		logic [X2W-1:0] r;
		ma = a[X2W-1] ? X2W'(-a) : X2W'(a);
		mb = b[X2W-1] ? X2W'(-b) : X2W'(b);
		pr = ma * mb + HALF;
		r = X2W'(pr >> FB);
		return (a[X2W-1] != b[X2W-1]) ? -$signed(r) : $signed(r);
	endfunction

	logic signed [X2W-1:0] xn_s1, xn_s2, xn_s3, xn_s4;
	logic signed [X2W-1:0] x2_s1, x2_s2, x2_s3;
	logic signed [X2W-1:0] p_s2, p_s3, p_s4;
	logic signed [X2W-1:0] s_full;

	assign s_full = fmul(xn_s4, p_s4);

	always_ff @(posedge clk) begin
		xn_s1 <= X2W'(xn);
		x2_s1 <= fmul(X2W'(xn), X2W'(xn));
		xn_s2 <= xn_s1;
		x2_s2 <= x2_s1;
		p_s2  <= K5_Q - fmul(x2_s1, K7_Q);
		xn_s3 <= xn_s2;
		x2_s3 <= x2_s2;
		p_s3  <= K3_Q - fmul(x2_s2, p_s2);
		xn_s4 <= xn_s3;
		p_s4  <= K1_Q - fmul(x2_s3, p_s3);
		s_s5  <= s_full[FB+2:0];
	end

endmodule
`default_nettype wire

/* hdl/tscp_div.sv */
// Tangent quotient by pipelined restoring division, result select and output register.
`default_nettype none
module tscp_div import tscp_pkg::*; #(
	parameter int AW = 32,
	parameter int FB = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctl_t                 ctl_in,
	input  wire logic signed [FB+2:0] s,
	input  wire logic signed [FB+2:0] c,
	output logic                      done,
	output logic [AW-1:0]             value,
	output logic                      saturated
);
	localparam int MW = FB + 3;
	localparam int NW = MW + FB + 1;
	localparam int CW = ((NW > AW) ? NW : AW) + 1;
	localparam logic [CW-1:0] OVER_LIM = (CW'(1) << AW) - CW'(1);
	localparam logic [AW-1:0] VMAX = (AW'(1) << (AW - 1)) - AW'(1);

	ctl_t           ctl_s  [0:NW];
	logic [MW-1:0]  uc_s   [0:NW];
	logic [MW-1:0]  rem_s  [0:NW];
	logic [NW-1:0]  num_s  [0:NW];
	logic [NW-1:0]  q_s    [0:NW];
	logic           neg_s  [0:NW];
	logic           sneg_s [0:NW];
	logic           cz_s   [0:NW];
	logic [AW-1:0]  pv_s   [0:NW];

	logic [MW-1:0] us, uc;
	logic [AW-1:0] pv;

	assign us = s[FB+2] ? MW'(-s) : MW'(s);
	assign uc = c[FB+2] ? MW'(-c) : MW'(c);

	always_comb begin
		case (cmd_t'(ctl_in.cmd))
			CMD_SIN: pv = AW'(s);
			CMD_COS: pv = AW'(c);
			default: pv = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		uc_s[0]   <= uc;
		rem_s[0]  <= '0;
		num_s[0]  <= {us, (FB+1)'(0)};
		q_s[0]    <= '0;
		neg_s[0]  <= s[FB+2] ^ c[FB+2];
		sneg_s[0] <= s[FB+2];
		cz_s[0]   <= (uc == '0);
		pv_s[0]   <= pv;
	end

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [MW:0] sh;
		logic        ge;
		assign sh = {rem_s[k], num_s[k][NW-1]};
		assign ge = (sh >= {1'b0, uc_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			uc_s[k+1]   <= uc_s[k];
			rem_s[k+1]  <= ge ? MW'(sh - {1'b0, uc_s[k]}) : sh[MW-1:0];
			num_s[k+1]  <= num_s[k] << 1;
			q_s[k+1]    <= {q_s[k][NW-2:0], ge};
			neg_s[k+1]  <= neg_s[k];
			sneg_s[k+1] <= sneg_s[k];
			cz_s[k+1]   <= cz_s[k];
			pv_s[k+1]   <= pv_s[k];
		end
	end

	// quotient carries one extra fraction bit: round by adding one and halving
	logic [CW-1:0] qe;
	logic [AW-1:0] qr;
	logic          over;
	logic [AW-1:0] val;
	logic          sat;

	assign qe   = CW'(q_s[NW]);
	assign qr   = AW'((qe + CW'(1)) >> 1);
	assign over = cz_s[NW] || (qe >= OVER_LIM);

	always_comb begin
		if (ctl_s[NW].vld && cmd_t'(ctl_s[NW].cmd) == CMD_TAN) begin
			sat = over;
			if (over) begin
				val = sneg_s[NW] ? -VMAX : VMAX;
			end else begin
				val = neg_s[NW] ? -qr : qr;
			end
		end else begin
			sat = 1'b0;
			val = pv_s[NW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s[NW].vld;
		end
	end

	always_ff @(posedge clk) begin
		value     <= val;
		saturated <= sat;
	end

endmodule
`default_nettype wire

/* hdl/trig_sin_cos_tan_poly.sv */
// Top level of the fixed-point sine, cosine and tangent evaluator.
`default_nettype none
// Pipelined sine/cosine/tangent of a signed fixed-point angle in radians. A beat
// is taken on every cycle that start is high; busy never rises, and the result
// shows on value/saturated for one cycle with done high. The depth is set by the
// angle reduction (one 2*pi compare-subtract stage per integer bit), five
// polynomial product stages, and the restoring tangent divider at one quotient
// bit per stage. Results come out in start order and cannot be held off by the
// receiver.
module trig_sin_cos_tan_poly import tscp_pkg::*; #(
	parameter int ANGLE_WIDTH = 32,
	parameter int FRAC_BITS   = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    cmd,
	input  wire logic signed [ANGLE_WIDTH-1:0] angle,
	output logic                               done,
	output logic signed [ANGLE_WIDTH-1:0]      value,
	output logic                               saturated
);
	localparam int AW = ANGLE_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int L1 = AW - FB + 7;
	localparam logic [63:0] HALF_PI_Q = half_pi_q(FB);

	ctl_t ctl_s [0:L1-1];

	logic signed [AW:0]   ang_x, ang_c;
	logic signed [FB+3:0] xn_sin, xn_cos;
	logic signed [FB+2:0] s_sin, s_cos;
	logic [AW-1:0]        val;

	assign busy  = 1'b0;
	assign ang_x = (AW+1)'(angle);
	assign ang_c = ang_x + $signed({1'b0, HALF_PI_Q[AW-1:0]});

	// carry command and valid alongside the reduction and polynomial stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L1; i++) ctl_s[i] <= '0;
		end else begin
			ctl_s[0] <= '{vld: start && !busy, cmd: cmd};
			for (int i = 1; i < L1; i++) ctl_s[i] <= ctl_s[i-1];
		end
	end

	tscp_reduce #(.AW(AW), .FB(FB)) u_red_sin (.clk(clk), .ang(ang_x), .xn_s(xn_sin));
	tscp_reduce #(.AW(AW), .FB(FB)) u_red_cos (.clk(clk), .ang(ang_c), .xn_s(xn_cos));

	tscp_poly #(.FB(FB)) u_poly_sin (.clk(clk), .xn(xn_sin), .s_s5(s_sin));
	tscp_poly #(.FB(FB)) u_poly_cos (.clk(clk), .xn(xn_cos), .s_s5(s_cos));

	tscp_div #(.AW(AW), .FB(FB)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(ctl_s[L1-1]),
		.s(s_sin),
		.c(s_cos),
		.done(done),
		.value(val),
		.saturated(saturated)
	);

	assign value = $signed(val);

endmodule
`default_nettype wire

/* hdl/tscp_check.sv */
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none
module tscp_check #(
	parameter int ANGLE_WIDTH = 32,
	parameter int FRAC_BITS   = 24
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic signed [ANGLE_WIDTH-1:0] value,
	input wire logic                          saturated
);
	localparam int LAT = (ANGLE_WIDTH - FRAC_BITS) + (2 * FRAC_BITS + 4) + 9;
	localparam logic signed [ANGLE_WIDTH-1:0] VMAX =
		(ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1)) - ANGLE_WIDTH'(1);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching start");

	a_sat_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		saturated |-> done)
		else $error("saturated outside a result beat");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (value == VMAX || value == -VMAX))
		else $error("saturated result is not full scale");

endmodule

bind trig_sin_cos_tan_poly tscp_check #(
	.ANGLE_WIDTH(ANGLE_WIDTH),
	.FRAC_BITS(FRAC_BITS)
) u_tscp_check (.*);
`default_nettype wire

/* tb/tb_trig_sin_cos_tan_poly.sv */
// Testbench for the sine/cosine/tangent evaluator: directed and random angles checked against a predictor.
`timescale 1ns / 100ps
module tb_trig_sin_cos_tan_poly;
	import tscp_pkg::*;

	localparam int AW = 32;
	localparam int FB = 24;
	localparam int LATENCY = (AW - FB) + (2 * FB + 4) + 9;
	localparam longint LIMIT = 2000000;
	localparam logic [63:0] VMAX = (64'd1 << (AW - 1)) - 1;
	localparam longint ONE_Q = longint'(1) << FB;
	localparam longint PI_Q = longint'(pi_q(FB));
	localparam longint TWO_PI_Q = longint'(two_pi_q(FB));
	localparam longint HALF_PI_Q = longint'(half_pi_q(FB));
	localparam longint K3_Q = (ONE_Q + 3) / 6;
	localparam longint K5_Q = (ONE_Q + 60) / 120;
	localparam longint K7_Q = (ONE_Q + 2520) / 5040;

	typedef struct {
		logic [1:0] cmd;
		logic [AW-1:0] angle;
	} angle_beat_t;

	typedef struct {
		logic [AW-1:0] value;
		logic saturated;
	} trig_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] cmd = CMD_SIN;
	logic signed [AW-1:0] angle = '0;
	wire busy;
	wire done;
	wire signed [AW-1:0] value;
	wire saturated;

	angle_beat_t pending_q[$];
	trig_result_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	bit stim_done = 0;
	int gap = 0;

	trig_sin_cos_tan_poly #(.ANGLE_WIDTH(AW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.angle(angle), .done(done), .value(value), .saturated(saturated)
	);

	always #10 clk = ~clk;

	// round(a*b / 2^FB), ties away from zero
	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [127:0] r;
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		r = (p + (128'd1 << (FB - 1))) >> FB;
		return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
	endfunction

	function automatic longint taylor_sine(input longint x);
		longint rem, xn, x2, p;
		rem = (x + PI_Q) % TWO_PI_Q;
		if (rem < 0) rem += TWO_PI_Q;
		xn = rem - PI_Q;
		x2 = fx_mul(xn, xn);
		p = K5_Q - fx_mul(x2, K7_Q);
		p = K3_Q - fx_mul(x2, p);
		p = ONE_Q - fx_mul(x2, p);
		return fx_mul(xn, p);
	endfunction

	function automatic trig_result_t predict_trig(input angle_beat_t b);
		trig_result_t r;
		longint x, s, c, val;
		logic [63:0] us, uc, q, rm;
		bit over;
		x = longint'(signed'(b.angle));
		val = 0;
		r.saturated = 0;
		case (b.cmd)
			CMD_SIN: val = taylor_sine(x);
			CMD_COS: val = taylor_sine(x + HALF_PI_Q);
			CMD_TAN: begin
				s = taylor_sine(x);
				c = taylor_sine(x + HALF_PI_Q);
				us = s < 0 ? -s : s;
				uc = c < 0 ? -c : c;
				over = (uc == 0);
				if (!over) begin
					q = us / uc;
					rm = us % uc;
					over = q > VMAX;
					for (int i = 0; i < FB && !over; i++) begin
						rm = rm << 1;
						q = q << 1;
						if (rm >= uc) begin
							rm -= uc;
							q[0] = 1'b1;
						end
						if (q > VMAX) over = 1;
					end
					if (!over) begin
						if ((rm << 1) >= uc) q++;
						if (q > VMAX) over = 1;
					end
					if (!over) val = ((s < 0) != (c < 0)) ? -longint'(q) : longint'(q);
				end
				if (over) begin
					r.saturated = 1;
					val = s < 0 ? -longint'(VMAX) : longint'(VMAX);
				end
			end
			default: val = 0;
		endcase
		r.value = val[AW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic push_angle(input logic [1:0] c, input logic [AW-1:0] a);
		angle_beat_t b;
		b.cmd = c;
		b.angle = a;
		pending_q.push_back(b);
	endtask

	// driver: present beats with random gaps, start low during a gap
	always @(posedge clk) begin
		angle_beat_t nb;
		if (arst_n) begin
			if (start && !busy) begin
				expected_q.push_back(predict_trig('{cmd, angle}));
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
			end
			if ((!start || !busy) && pending_q.size() > 0 && gap == 0) begin
				nb = pending_q.pop_front();
				start <= 1;
				cmd <= nb.cmd;
				angle <= nb.angle;
			end else if (!start || !busy) begin
				start <= 0;
				if (gap > 0) gap--;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		trig_result_t e;
		cycles++;
		if (done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = expected_q.pop_front();
				if (value !== e.value)
					report_mismatch($sformatf("value %h, expected %h", value, e.value));
				if (saturated !== e.saturated)
					report_mismatch($sformatf("saturated %b, expected %b", saturated,
						e.saturated));
			end
		end
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [AW-1:0] a;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, zero, multiples of pi/2, unused code
		for (int c = 0; c < 4; c++) begin
			push_angle(c[1:0], 32'h8000_0000);
			push_angle(c[1:0], 32'h7FFF_FFFF);
			push_angle(c[1:0], 32'd0);
			push_angle(c[1:0], AW'(PI_Q));
			push_angle(c[1:0], AW'(-PI_Q));
		end
		push_angle(CMD_TAN, AW'(HALF_PI_Q));
		push_angle(CMD_TAN, AW'(-HALF_PI_Q));
		push_angle(CMD_TAN, AW'(HALF_PI_Q + 1));
		push_angle(CMD_TAN, AW'(HALF_PI_Q - 1));
		for (int n = 0; n < 1150; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) a = $urandom;
			// near pi/2 multiples: tangent saturation region
			else if (pick < 7)
				a = AW'(HALF_PI_Q * ($urandom_range(0, 20) - 10) +
					($urandom_range(0, 64) - 32));
			else a = AW'(longint'($urandom_range(0, 2 * TWO_PI_Q)) - TWO_PI_Q);
			push_angle($urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)), a);
		end
		wait (pending_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
